### design/vood_pkg.sv
// ----------------------------------------------------------------------------
// vood_pkg
// Shared types and constants of the octree occupancy decoder.
// ----------------------------------------------------------------------------
package vood_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_CH_RD,
		ST_CH_WR,
		ST_FIN,
		ST_ROOT,
		ST_CLEAR
	} state_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_BUSY  = 2'd0,
		STAT_DONE  = 2'd1,
		STAT_SHORT = 2'd2,
		STAT_LONG  = 2'd3
	} status_t;

	// answer of the chunk finder
	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} find_t;

	localparam int CHUNK_W = 8;
	localparam int LVL_W   = 3;
	localparam int COORD_W = 7;

	// number of set bits in a mask byte
	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(v[i]);
		end
		return c;
	endfunction

endpackage

### design/voxel_octree_occupancy_decoder.sv
// ----------------------------------------------------------------------------
// voxel_octree_occupancy_decoder
// Breadth-first octree occupancy stream decoder with bitmaps in two banks that alternate by level.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                              | tlast
//  s_*     | in  | code_byte[7:0]                                  | end_of_stream
//  m_*     | out | tree_level[2:0] cell_red[9:3] cell_green[16:10] | -
//          |     | cell_blue[23:17] child_mask[31:24] status[33:32] |
//
// A byte is accepted; each bitmap row the scan visits is then read and checked
// one 8-cell chunk at a time, four child rows are read and written back (none
// on the last level), and the result is posted (at once if the tree is done).
// Moving to a new level clears the bitmap rows of the level after it, if any,
// one row a cycle. After reset and after each end of stream the root is
// written and level 1 cleared. No byte is taken meanwhile.
// A stalled output holds its word; the next byte is taken while it waits.
// ----------------------------------------------------------------------------
module voxel_octree_occupancy_decoder #(
	parameter int LEVELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // code_byte
	input  logic        s_tlast,   // end_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // tree_level, cell_red, cell_green, cell_blue,
	                               // child_mask, status
);

	localparam int RW   = 1 << (LEVELS - 1);
	localparam int WW   = (RW < 8) ? 8 : RW;
	localparam int NCH  = WW / 8;
	localparam int CIW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CLW  = $clog2(WW);
	localparam int AW   = 2 * (LEVELS - 1);
	localparam int CNTW = 3 * (LEVELS - 1) + 1;

	vood_pkg::state_t  state_q, state_d;
	logic [7:0]        mask_q;
	logic              eos_q;
	logic [2:0]        lvl_q;
	logic [CNTW-1:0]   left_q, next_q;
	logic [AW:0]       row_q;
	logic [CLW-1:0]    col_q;
	logic              done_q;
	logic [1:0]        step_q;
	logic [AW:0]       clr_q;
	logic [2:0]        clr_lvl_q;

	logic              m_valid_q;
	logic [33:0]       m_word_q;

	// memory controls
	logic              wr_en, rd_en;
	logic [AW:0]       wr_addr, rd_addr;
	logic [WW-1:0]     wr_data, rd_data;

	// level geometry
	logic [CLW:0]      n_val;
	logic [CLW-1:0]    nm1;
	logic [AW:0]       rows_val, rows_clr;
	logic [AW:0]       g_val, b_val;
	logic              last_lvl, clr_next;

	// scan
	logic [CIW-1:0]    chunk_idx;
	logic [7:0]        chunk, lim;
	logic [CLW:0]      chunk_base, next_base;
	vood_pkg::find_t   fres;

	// child update
	logic [AW:0]       cb, cg, crow;
	logic [WW-1:0]     cbits;

	// finish
	logic              out_free;
	logic [CNTW-1:0]   left_n, next_n;
	logic              fin_lvl, done_n, advance;
	vood_pkg::status_t stat_n;

	vood_bitmap_ram #(.AW(AW + 1), .WW(WW)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	vood_chunk_find u_find (
		.chunk (chunk),
		.lo    (col_q[2:0]),
		.lim   (lim),
		.res   (fres)
	);

	// geometry of the current level
	always_comb begin
		n_val    = (CLW + 1)'(1) << lvl_q;
		nm1      = CLW'(n_val - (CLW + 1)'(1));
		rows_val = (AW + 1)'(1) << {lvl_q, 1'b0};
		rows_clr = (AW + 1)'(1) << {clr_lvl_q, 1'b0};
		g_val    = row_q & (AW + 1)'(nm1);
		b_val    = row_q >> lvl_q;
		last_lvl = ({1'b0, lvl_q} + 4'd1) >= 4'(LEVELS);
		clr_next = ({1'b0, lvl_q} + 4'd2) < 4'(LEVELS);
	end

	// chunk selection for the scan
	always_comb begin
		chunk_idx  = CIW'(col_q >> 3);
		chunk      = rd_data[chunk_idx * 8 +: 8];
		chunk_base = (CLW + 1)'(chunk_idx) << 3;
		next_base  = chunk_base + (CLW + 1)'(8);
		for (int j = 0; j < 8; j++) begin
			lim[j] = (chunk_base + (CLW + 1)'(j)) < n_val;
		end
	end

	// child row address and bits
	always_comb begin
		cb   = {b_val[AW-1:0], step_q[1]};
		cg   = {g_val[AW-1:0], step_q[0]};
		crow = (cb << ({1'b0, lvl_q} + 4'd1)) | cg;
		for (int j = 0; j < WW; j++) begin
			cbits[j] = (CLW'(j >> 1) == col_q) && mask_q[{step_q, 1'(j & 1)}];
		end
	end

	// counters at the end of a byte
	always_comb begin
		out_free = !m_valid_q || m_tready;
		left_n   = (left_q != '0) ? left_q - CNTW'(1) : left_q;
		next_n   = last_lvl ? next_q : next_q + CNTW'(vood_pkg::popcount8(mask_q));
		fin_lvl  = (left_n == '0);
		done_n   = fin_lvl && (last_lvl || next_n == '0);
		advance  = fin_lvl && !done_n;
		if (done_n) begin
			stat_n = vood_pkg::STAT_DONE;
		end else if (eos_q) begin
			stat_n = vood_pkg::STAT_SHORT;
		end else begin
			stat_n = vood_pkg::STAT_BUSY;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vood_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = done_q ? vood_pkg::ST_FIN : vood_pkg::ST_SCAN_RD;
				end
			end
			vood_pkg::ST_SCAN_RD: begin
				if (row_q >= rows_val) begin
					state_d = last_lvl ? vood_pkg::ST_FIN : vood_pkg::ST_CH_RD;
				end else begin
					state_d = vood_pkg::ST_SCAN_CHK;
				end
			end
			vood_pkg::ST_SCAN_CHK: begin
				if (fres.hit) begin
					state_d = last_lvl ? vood_pkg::ST_FIN : vood_pkg::ST_CH_RD;
				end else if (next_base >= n_val) begin
					state_d = vood_pkg::ST_SCAN_RD;
				end
			end
			vood_pkg::ST_CH_RD: state_d = vood_pkg::ST_CH_WR;
			vood_pkg::ST_CH_WR: begin
				if (step_q == 2'd3) begin
					state_d = vood_pkg::ST_FIN;
				end else begin
					state_d = vood_pkg::ST_CH_RD;
				end
			end
			vood_pkg::ST_FIN: begin
				if (out_free) begin
					if (eos_q) begin
						state_d = vood_pkg::ST_ROOT;
					end else if (!done_q && advance && clr_next) begin
						state_d = vood_pkg::ST_CLEAR;
					end else begin
						state_d = vood_pkg::ST_IDLE;
					end
				end
			end
			vood_pkg::ST_ROOT: state_d = vood_pkg::ST_CLEAR;
			vood_pkg::ST_CLEAR: begin
				if (clr_q == rows_clr - (AW + 1)'(1)) begin
					state_d = vood_pkg::ST_IDLE;
				end
			end
			default: state_d = vood_pkg::ST_ROOT;
		endcase
	end

	// memory port drive
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			vood_pkg::ST_SCAN_RD: begin
				rd_en   = 1'b1;
				rd_addr = {lvl_q[0], row_q[AW-1:0]};
			end
			vood_pkg::ST_CH_RD: begin
				rd_en   = 1'b1;
				rd_addr = {~lvl_q[0], crow[AW-1:0]};
			end
			vood_pkg::ST_CH_WR: begin
				wr_en   = 1'b1;
				wr_addr = {~lvl_q[0], crow[AW-1:0]};
				wr_data = rd_data | cbits;
			end
			vood_pkg::ST_ROOT: begin
				wr_en   = 1'b1;
				wr_data = WW'(1);
			end
			vood_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = {clr_lvl_q[0], clr_q[AW-1:0]};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == vood_pkg::ST_IDLE);

	// sequencer and decode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vood_pkg::ST_ROOT;
			lvl_q     <= '0;
			left_q    <= CNTW'(1);
			next_q    <= '0;
			row_q     <= '0;
			col_q     <= '0;
			done_q    <= 1'b0;
			step_q    <= '0;
			clr_q     <= '0;
			clr_lvl_q <= 3'd1;
			m_valid_q <= 1'b0;
			m_word_q  <= '0;
		end else begin
			state_q <= state_d;
			// output word valid
			if (state_q == vood_pkg::ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				vood_pkg::ST_SCAN_RD: begin
					step_q <= '0;
					// no occupied cell left: take the last cell
					if (row_q >= rows_val) begin
						row_q <= rows_val - (AW + 1)'(1);
						col_q <= nm1;
					end
				end
				vood_pkg::ST_SCAN_CHK: begin
					if (fres.hit) begin
						col_q <= CLW'({chunk_idx, fres.idx});
					end else if (next_base >= n_val) begin
						row_q <= row_q + (AW + 1)'(1);
						col_q <= '0;
					end else begin
						col_q <= CLW'(next_base);
					end
				end
				vood_pkg::ST_CH_WR: begin
					step_q <= step_q + 2'd1;
				end
				vood_pkg::ST_FIN: begin
					if (out_free) begin
						if (done_q) begin
							m_word_q <= {vood_pkg::STAT_LONG, 32'd0};
						end else begin
							m_word_q <= {stat_n, mask_q, 7'(b_val), 7'(g_val), 7'(col_q), lvl_q};
							if (done_n) begin
								done_q <= 1'b1;
							end
							if (advance) begin
								lvl_q     <= lvl_q + 3'd1;
								left_q    <= next_n;
								next_q    <= '0;
								row_q     <= '0;
								col_q     <= '0;
								clr_lvl_q <= lvl_q + 3'd2;
							end else begin
								left_q <= left_n;
								next_q <= next_n;
								if (col_q == nm1) begin
									col_q <= '0;
									row_q <= row_q + (AW + 1)'(1);
								end else begin
									col_q <= col_q + CLW'(1);
								end
							end
						end
					end
				end
				vood_pkg::ST_ROOT: begin
					lvl_q     <= '0;
					left_q    <= CNTW'(1);
					next_q    <= '0;
					row_q     <= '0;
					col_q     <= '0;
					done_q    <= 1'b0;
					clr_q     <= '0;
					clr_lvl_q <= 3'd1;
				end
				vood_pkg::ST_CLEAR: begin
					if (clr_q == rows_clr - (AW + 1)'(1)) begin
						clr_q <= '0;
					end else begin
						clr_q <= clr_q + (AW + 1)'(1);
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// input word latch
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mask_q <= s_tdata;
			eos_q  <= s_tlast;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, m_word_q};

	// a taken byte leaves the sequencer busy, so no byte is taken back to back
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("byte taken back to back");

	// surplus bytes carry no cell
	a_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[33:32] == vood_pkg::STAT_LONG) |-> (m_tdata[31:0] == 32'd0))
		else $error("too-many word carries cell data");

	// a complete tree owes no bytes
	a_done_left: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (left_q == '0))
		else $error("tree complete with bytes left");

	// level stays inside the pyramid
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, lvl_q} < 4'(LEVELS)))
		else $error("level out of range");

endmodule

### design/vood_bitmap_ram.sv
// ----------------------------------------------------------------------------
// vood_bitmap_ram
// Occupancy bitmap store, one row of cells per word, registered read.
// ----------------------------------------------------------------------------
module vood_bitmap_ram #(
	parameter int AW = 15,
	parameter int WW = 128
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [WW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [WW-1:0] rd_data
);

	logic [WW-1:0] mem_q [2**AW];
	logic [WW-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/vood_chunk_find.sv
// ----------------------------------------------------------------------------
// vood_chunk_find
// Finds the lowest occupied cell of one 8-cell chunk at or above a start column.
// ----------------------------------------------------------------------------
module vood_chunk_find (
	input  logic                [7:0] chunk,
	input  logic                [2:0] lo,
	input  logic                [7:0] lim,
	output vood_pkg::find_t           res
);

	logic [7:0] cand;

	// keep cells at or above the start and inside the grid
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			cand[j] = chunk[j] && lim[j] && (3'(j) >= lo);
		end
	end

	// lowest candidate wins
	always_comb begin
		res.hit = 1'b0;
		res.idx = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (cand[j]) begin
				res.hit = 1'b1;
				res.idx = 3'(j);
			end
		end
	end

endmodule
